// File: sv/fes_pkg.sv
// Shared types and constants for the function end scanner.
// Depends on nothing; imported by the front decoder, the back end and the top level.
package fes_pkg;

   localparam logic [31:0] WORD_RETURN_LR = 32'h4E80_0020;
   localparam logic [31:0] WORD_JUMP_CTR  = 32'h4E80_0420;

   localparam logic [5:0] OP_BC   = 6'd16;
   localparam logic [5:0] OP_B    = 6'd18;
   localparam logic [5:0] OP_XL   = 6'd19;
   localparam logic [5:0] OP_X    = 6'd31;

   localparam logic [9:0] XO_BCLR   = 10'd16;
   localparam logic [9:0] XO_BCCTR  = 10'd528;
   localparam logic [9:0] XO_MFSPR  = 10'd339;

   localparam logic [4:0] SPR_HALF_MASK = 5'h1F;
   localparam logic [9:0] SPR_LINK      = 10'd8;

   localparam logic CSR_START_ADDR   = 1'b0;
   localparam logic CSR_EXPECTED_END = 1'b1;

   typedef enum logic [2:0] {
      REASON_NONE     = 3'd0,
      REASON_ZERO     = 3'd1,
      REASON_RETURN   = 3'd2,
      REASON_BACK     = 3'd3,
      REASON_TAIL     = 3'd4,
      REASON_EPILOG   = 3'd5,
      REASON_THUNK    = 3'd6,
      REASON_OVERRUN  = 3'd7
   } end_reason_type;

   typedef struct packed {
      logic [31:0] start_addr;
      logic [31:0] expected_end;
   } cfg_type;

   // One classified instruction word as it travels from front to back.
   typedef struct packed {
      logic        begin_req;
      logic        is_zero;
      logic        is_return;
      logic        is_branch;
      logic        is_cond_branch;
      logic        is_reg_branch;
      logic        is_mflr;
      logic        link;
      logic        abs_target;
      logic        epilog;
      logic [31:0] disp;
   } dec_type;

   typedef struct packed {
      logic [31:0]    instr_address;
      logic           block_end;
      logic           function_done;
      end_reason_type end_reason;
      logic [31:0]    final_end;
      logic           ran_under;
   } rsp_type;

endpackage

// File: sv/fes_fifo.sv
// Small register queue with registered storage and a fill count.
// Stand-alone; used between front and back and on the result side.
module fes_fifo #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 2
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  logic [WIDTH-1:0] wdata,
   output logic             full,
   input  logic             pop,
   output logic [WIDTH-1:0] rdata,
   output logic             empty
);

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);

   logic [WIDTH-1:0] store_ff [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic             do_push, do_pop;

   assign full    = (count_ff == CNT_W'(DEPTH));
   assign empty   = (count_ff == '0);
   assign do_push = push && !full;
   assign do_pop  = pop && !empty;
   assign rdata   = store_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         store_ff[wr_ptr_ff] <= wdata;
      end
   end

endmodule

// File: sv/fes_decode.sv
// Front decoder: classifies one instruction word into its branch form and displacement.
// Depends on fes_pkg.
module fes_decode (
   input  logic            begin_req,
   input  logic [31:0]     instr_word,
   input  logic            target_is_epilog,
   output fes_pkg::dec_type dec
);
   import fes_pkg::*;

   logic [5:0] primary;
   logic [9:0] xo;
   logic [9:0] spr;
   logic [9:0] spr_swapped;

   always_comb begin
      primary     = instr_word[31:26];
      xo          = instr_word[10:1];
      spr         = instr_word[20:11];
      spr_swapped = {spr[4:0] & SPR_HALF_MASK, spr[9:5] & SPR_HALF_MASK};

      dec.begin_req      = begin_req;
      dec.epilog         = target_is_epilog;
      dec.is_zero        = (instr_word == '0);
      dec.is_return      = (instr_word == WORD_RETURN_LR) || (instr_word == WORD_JUMP_CTR);
      dec.is_branch      = (primary == OP_B);
      dec.is_cond_branch = (primary == OP_BC);
      dec.is_reg_branch  = (primary == OP_XL) && ((xo == XO_BCLR) || (xo == XO_BCCTR));
      dec.is_mflr        = (primary == OP_X) && (xo == XO_MFSPR) && (spr_swapped == SPR_LINK);
      dec.link           = instr_word[0];
      dec.abs_target     = instr_word[1];
      // b carries a 24-bit word offset, bc a 14-bit one
      if (primary == OP_B) begin
         dec.disp = {{6{instr_word[25]}}, instr_word[25:2], 2'b00};
      end else begin
         dec.disp = {{16{instr_word[15]}}, instr_word[15:2], 2'b00};
      end
   end

endmodule

// File: sv/fes_exec.sv
// Back end: holds the scan state, resolves targets and applies the end-of-function rules.
// Depends on fes_pkg; fed from the decoded-word queue, feeds the result queue.
module fes_exec (
   input  logic             clock,
   input  logic             reset,
   input  fes_pkg::cfg_type cfg,
   input  fes_pkg::dec_type dec,
   input  logic             dec_valid,
   output logic             dec_take,
   input  logic             rsp_full,
   output logic             rsp_push,
   output fes_pkg::rsp_type rsp
);
   import fes_pkg::*;

   logic [31:0] scan_address_ff, scan_address_in;
   logic [31:0] furthest_ff, furthest_in;
   logic [1:0]  block_count_ff, block_count_in;
   logic        inside_block_ff, inside_block_in;
   logic        link_prolog_ff, link_prolog_in;
   logic        scan_active_ff, scan_active_in;

   logic [31:0] addr, furthest;
   logic [1:0]  block_count;
   logic        inside_block, link_prolog, active;
   logic [31:0] addr_plus4, addr_plus8, target, under_cmp;
   logic        clear, ends_fn, closes_block, done;
   end_reason_type reason;
   logic [31:0] final_end;

   always_comb begin
      dec_take = dec_valid && !rsp_full;

      // a begin word restarts from the configured start address
      if (dec.begin_req) begin
         addr         = cfg.start_addr;
         furthest     = cfg.start_addr;
         block_count  = '0;
         inside_block = 1'b0;
         link_prolog  = 1'b0;
         active       = 1'b1;
      end else begin
         addr         = scan_address_ff;
         furthest     = furthest_ff;
         block_count  = block_count_ff;
         inside_block = inside_block_ff;
         link_prolog  = link_prolog_ff;
         active       = scan_active_ff;
      end

      addr_plus4 = addr + 32'd4;
      addr_plus8 = addr + 32'd8;
      target     = dec.disp + (dec.abs_target ? 32'd0 : addr);
      clear      = (furthest <= addr);

      scan_address_in = addr;
      furthest_in     = furthest;
      block_count_in  = block_count;
      inside_block_in = inside_block;
      link_prolog_in  = link_prolog;
      ends_fn         = 1'b0;
      closes_block    = 1'b0;
      done            = 1'b0;
      reason          = REASON_NONE;
      final_end       = '0;
      under_cmp       = addr;

      if (dec.is_zero) begin
         done      = 1'b1;
         reason    = REASON_ZERO;
         final_end = addr - 32'd4;
         under_cmp = addr;
      end else begin
         if (dec.is_mflr && (addr == cfg.start_addr)) begin
            link_prolog_in = 1'b1;
         end
         if (!inside_block) begin
            inside_block_in = 1'b1;
            if (block_count != 2'd3) begin
               block_count_in = block_count + 2'd1;
            end
         end

         if (dec.is_return) begin
            if (clear) begin
               ends_fn = 1'b1;
               reason  = REASON_RETURN;
            end
            closes_block = 1'b1;
         end else if (dec.is_branch) begin
            if (!dec.link) begin
               if ((target >= cfg.start_addr) && (target < addr) && clear) begin
                  ends_fn = 1'b1;
                  reason  = REASON_BACK;
               end else if ((target < cfg.start_addr) && clear) begin
                  ends_fn = 1'b1;
                  reason  = REASON_TAIL;
               end else if (clear && dec.epilog) begin
                  ends_fn = 1'b1;
                  reason  = REASON_EPILOG;
               end else if (!link_prolog_in && (block_count_in == 2'd1)) begin
                  ends_fn = 1'b1;
                  reason  = REASON_THUNK;
               end
               if (!ends_fn && !dec.epilog && (target > furthest)) begin
                  furthest_in = target;
               end
            end
            closes_block = 1'b1;
         end else if (dec.is_cond_branch) begin
            if (!dec.link && !dec.epilog && (target > furthest)) begin
               furthest_in = target;
            end
            closes_block = 1'b1;
         end else if (dec.is_reg_branch) begin
            closes_block = 1'b1;
         end

         if (closes_block) begin
            inside_block_in = 1'b0;
         end
         if (ends_fn) begin
            done      = 1'b1;
            final_end = addr;
            under_cmp = addr_plus4;
         end else begin
            scan_address_in = addr_plus4;
            if ((cfg.expected_end != '0) && (addr_plus4 > cfg.expected_end)) begin
               done      = 1'b1;
               reason    = REASON_OVERRUN;
               final_end = addr_plus4;
               under_cmp = addr_plus8;
            end
         end
      end

      scan_active_in = active && !done;

      rsp_push          = dec_take && active;
      rsp.instr_address = addr;
      rsp.block_end     = closes_block;
      rsp.function_done = done;
      rsp.end_reason    = reason;
      rsp.final_end     = final_end;
      rsp.ran_under     = done && (cfg.expected_end != '0) && (under_cmp < cfg.expected_end);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         scan_address_ff <= '0;
         furthest_ff     <= '0;
         block_count_ff  <= '0;
         inside_block_ff <= 1'b0;
         link_prolog_ff  <= 1'b0;
         scan_active_ff  <= 1'b0;
      end else if (dec_take && active) begin
         scan_address_ff <= scan_address_in;
         furthest_ff     <= furthest_in;
         block_count_ff  <= block_count_in;
         inside_block_ff <= inside_block_in;
         link_prolog_ff  <= link_prolog_in;
         scan_active_ff  <= scan_active_in;
      end
   end

`ifndef SYNTH
   a_done_has_reason: assert property (@(posedge clock) disable iff (reset)
      rsp_push && rsp.function_done |-> rsp.end_reason != REASON_NONE)
      else $error("finished scan without an end reason");

   a_open_scan_quiet: assert property (@(posedge clock) disable iff (reset)
      rsp_push && !rsp.function_done |-> rsp.final_end == '0 && !rsp.ran_under)
      else $error("end address or underrun reported on an open scan");

   a_done_stops_scan: assert property (@(posedge clock) disable iff (reset)
      rsp_push && rsp.function_done |=> !scan_active_ff)
      else $error("scan still active after function end");

   a_zero_no_block: assert property (@(posedge clock) disable iff (reset)
      rsp_push && rsp.end_reason == REASON_ZERO |-> !rsp.block_end)
      else $error("zero word reported as block end");

   a_idle_no_result: assert property (@(posedge clock) disable iff (reset)
      dec_take && !dec.begin_req && !scan_active_ff |-> !rsp_push)
      else $error("result produced while no scan is active");
`endif

endmodule

// File: sv/function_end_scanner.sv
// Each word is registered in the decoded-word queue, then the back end resolves its target add
// and compares combinationally and registers the result in the result queue, ready to be popped.
// Throughput: one word per cycle while the result queue is not full.
// A decoded-word queue and a result queue of QUEUE_DEPTH entries each let either side stall alone.
// Words taken while no scan is active and without begin_req give no result.
// Reset (synchronous, active high) empties both queues and clears the scan state and registers.
module function_end_scanner #(
   parameter int QUEUE_DEPTH = 2
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_push,
   output logic        req_full,
   input  logic        req_begin_req,
   input  logic [31:0] req_instr_word,
   input  logic        req_target_is_epilog,
   output logic        rsp_empty,
   input  logic        rsp_pop,
   output logic [31:0] rsp_instr_address,
   output logic        rsp_block_end,
   output logic        rsp_function_done,
   output logic [2:0]  rsp_end_reason,
   output logic [31:0] rsp_final_end,
   output logic        rsp_ran_under,
   input  logic        csr_we,
   input  logic        csr_index,
   input  logic [31:0] csr_data
);
   import fes_pkg::*;

   localparam int DEC_W = $bits(dec_type);
   localparam int RSP_W = $bits(rsp_type);

   logic [31:0] start_addr_ff;
   logic [31:0] expected_end_ff;
   cfg_type     cfg;

   dec_type          dec_front, dec_back;
   logic [DEC_W-1:0] dec_rdata;
   logic             dec_empty, dec_take;
   logic             res_full, res_push;
   rsp_type          res_back, res_out;
   logic [RSP_W-1:0] res_rdata;

   always_ff @(posedge clock) begin
      if (reset) begin
         start_addr_ff   <= '0;
         expected_end_ff <= '0;
      end else if (csr_we) begin
         unique case (csr_index)
            CSR_START_ADDR:   start_addr_ff   <= csr_data;
            CSR_EXPECTED_END: expected_end_ff <= csr_data;
            default: ;
         endcase
      end
   end

   assign cfg.start_addr   = start_addr_ff;
   assign cfg.expected_end = expected_end_ff;

   fes_decode u_decode (
      .begin_req        (req_begin_req),
      .instr_word       (req_instr_word),
      .target_is_epilog (req_target_is_epilog),
      .dec              (dec_front)
   );

   fes_fifo #(.WIDTH(DEC_W), .DEPTH(QUEUE_DEPTH)) u_dec_queue (
      .clock (clock),
      .reset (reset),
      .push  (req_push),
      .wdata (dec_front),
      .full  (req_full),
      .pop   (dec_take),
      .rdata (dec_rdata),
      .empty (dec_empty)
   );

   assign dec_back = dec_type'(dec_rdata);

   fes_exec u_exec (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg),
      .dec       (dec_back),
      .dec_valid (!dec_empty),
      .dec_take  (dec_take),
      .rsp_full  (res_full),
      .rsp_push  (res_push),
      .rsp       (res_back)
   );

   fes_fifo #(.WIDTH(RSP_W), .DEPTH(QUEUE_DEPTH)) u_rsp_queue (
      .clock (clock),
      .reset (reset),
      .push  (res_push),
      .wdata (res_back),
      .full  (res_full),
      .pop   (rsp_pop),
      .rdata (res_rdata),
      .empty (rsp_empty)
   );

   assign res_out           = rsp_type'(res_rdata);
   assign rsp_instr_address = res_out.instr_address;
   assign rsp_block_end     = res_out.block_end;
   assign rsp_function_done = res_out.function_done;
   assign rsp_end_reason    = res_out.end_reason;
   assign rsp_final_end     = res_out.final_end;
   assign rsp_ran_under     = res_out.ran_under;

endmodule

// File: verif/function_end_checker.sv
`timescale 1ns / 1ps
// Watches the word and result channels of the function end scanner, predicts each result
// from the words it accepts and the register writes it sees, and compares in order.
// Depends on fes_pkg for the opcode constants, the end reason codes and the result layout.
module function_end_checker (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_push,
   input  logic        req_full,
   input  logic        req_begin_req,
   input  logic [31:0] req_instr_word,
   input  logic        req_target_is_epilog,
   input  logic        rsp_empty,
   input  logic        rsp_pop,
   input  logic [31:0] rsp_instr_address,
   input  logic        rsp_block_end,
   input  logic        rsp_function_done,
   input  logic [2:0]  rsp_end_reason,
   input  logic [31:0] rsp_final_end,
   input  logic        rsp_ran_under,
   input  logic        csr_we,
   input  logic        csr_index,
   input  logic [31:0] csr_data,
   output int          mismatches,
   output int          awaited,
   output int          predicted
);
   import fes_pkg::*;

   localparam int PRINT_CAP = 200;

   logic [31:0] cfg_start;
   logic [31:0] cfg_end;
   logic [31:0] scan_at;
   logic [31:0] far_target;
   logic [1:0]  block_tally;
   logic        blk_open;
   logic        saw_mflr;
   logic        scanning;

   rsp_type pending_rsp[$];
   int      miss_count = 0;
   int      held = 0;
   int      made = 0;

   assign mismatches = miss_count;
   assign awaited    = held;
   assign predicted  = made;

   task automatic flag(input string what, input logic [31:0] got, input logic [31:0] want);
      if (miss_count < PRINT_CAP)
         $display("%0t: %s mismatch: got %h, expected %h", $realtime, what, got, want);
      miss_count++;
   endtask

   // Walk one word through the scan and queue the result it gives, if any.
   task automatic examine_word(input logic begin_req, input logic [31:0] word,
                               input logic epilog);
      rsp_type        r;
      logic [31:0]    addr;
      logic [31:0]    target;
      logic [31:0]    last;
      logic [5:0]     opcode;
      logic [9:0]     xo;
      logic [9:0]     spr;
      logic           ends_fn;
      logic           closes_block;
      logic           done;
      logic           clear;
      end_reason_type why;

      if (begin_req) begin
         scan_at     = cfg_start;
         far_target  = cfg_start;
         block_tally = 2'd0;
         blk_open    = 1'b0;
         saw_mflr    = 1'b0;
         scanning    = 1'b1;
      end
      if (!scanning)
         return;

      addr         = scan_at;
      opcode       = word[31:26];
      xo           = word[10:1];
      spr          = word[20:11];
      ends_fn      = 1'b0;
      closes_block = 1'b0;
      done         = 1'b0;
      last         = '0;
      why          = REASON_NONE;

      if (word == '0) begin
         done = 1'b1;
         why  = REASON_ZERO;
         last = addr - 32'd4;
      end else begin
         // spr halves are swapped in the encoding
         if (addr == cfg_start && opcode == OP_X && xo == XO_MFSPR &&
             {spr[4:0], spr[9:5]} == SPR_LINK)
            saw_mflr = 1'b1;

         if (!blk_open) begin
            blk_open = 1'b1;
            if (block_tally != 2'd3)
               block_tally = block_tally + 2'd1;
         end

         if (word == WORD_RETURN_LR || word == WORD_JUMP_CTR) begin
            if (far_target <= addr) begin
               ends_fn = 1'b1;
               why     = REASON_RETURN;
            end
            closes_block = 1'b1;
         end else if (opcode == OP_B) begin
            target = {{6{word[25]}}, word[25:2], 2'b00};
            if (!word[1])
               target = target + addr;
            if (!word[0]) begin
               clear = far_target <= addr;
               if (clear && target >= cfg_start && target < addr) begin
                  ends_fn = 1'b1;
                  why     = REASON_BACK;
               end else if (clear && target < cfg_start) begin
                  ends_fn = 1'b1;
                  why     = REASON_TAIL;
               end else if (clear && epilog) begin
                  ends_fn = 1'b1;
                  why     = REASON_EPILOG;
               end else if (!saw_mflr && block_tally == 2'd1) begin
                  ends_fn = 1'b1;
                  why     = REASON_THUNK;
               end
               if (!ends_fn && !epilog && target > far_target)
                  far_target = target;
            end
            closes_block = 1'b1;
         end else if (opcode == OP_BC) begin
            target = {{16{word[15]}}, word[15:2], 2'b00};
            if (!word[1])
               target = target + addr;
            if (!word[0] && !epilog && target > far_target)
               far_target = target;
            closes_block = 1'b1;
         end else if (opcode == OP_XL && (xo == XO_BCLR || xo == XO_BCCTR)) begin
            closes_block = 1'b1;
         end

         if (closes_block)
            blk_open = 1'b0;
         if (ends_fn) begin
            done = 1'b1;
            last = addr;
         end else begin
            scan_at = addr + 32'd4;
            if (cfg_end != '0 && scan_at > cfg_end) begin
               done = 1'b1;
               why  = REASON_OVERRUN;
               last = scan_at;
            end
         end
      end

      if (done)
         scanning = 1'b0;

      r.instr_address = addr;
      r.block_end     = closes_block;
      r.function_done = done;
      r.end_reason    = why;
      r.final_end     = done ? last : '0;
      r.ran_under     = done && cfg_end != '0 && (last + 32'd4) < cfg_end;
      pending_rsp.insert(pending_rsp.size(), r);
      made++;
   endtask

   always @(posedge clock) begin : watch
      rsp_type want;
      if (reset) begin
         cfg_start   = '0;
         cfg_end     = '0;
         scan_at     = '0;
         far_target  = '0;
         block_tally = 2'd0;
         blk_open    = 1'b0;
         saw_mflr    = 1'b0;
         scanning    = 1'b0;
         pending_rsp.delete();
      end else begin
         if (rsp_pop && !rsp_empty) begin
            if (pending_rsp.size() == 0) begin
               flag("unawaited result word, instr_address", rsp_instr_address, '0);
            end else begin
               want = pending_rsp.pop_front();
               if (rsp_instr_address !== want.instr_address)
                  flag("instr_address", rsp_instr_address, want.instr_address);
               if (rsp_block_end !== want.block_end)
                  flag("block_end", 32'(rsp_block_end), 32'(want.block_end));
               if (rsp_function_done !== want.function_done)
                  flag("function_done", 32'(rsp_function_done), 32'(want.function_done));
               if (rsp_end_reason !== want.end_reason)
                  flag("end_reason", 32'(rsp_end_reason), 32'(want.end_reason));
               if (rsp_final_end !== want.final_end)
                  flag("final_end", rsp_final_end, want.final_end);
               if (rsp_ran_under !== want.ran_under)
                  flag("ran_under", 32'(rsp_ran_under), 32'(want.ran_under));
            end
         end
         if (csr_we) begin
            if (csr_index == CSR_START_ADDR)
               cfg_start = csr_data;
            else
               cfg_end = csr_data;
         end
         if (req_push && !req_full)
            examine_word(req_begin_req, req_instr_word, req_target_is_epilog);
      end
      held <= pending_rsp.size();
   end

endmodule

// File: verif/tb_function_end_scanner.sv
`timescale 1ns / 1ps
// Top of the function end scanner testbench: clock, reset, register writes and the word
// stream (directed scans, then random scans), with random stalls on the result side.
// Depends on fes_pkg, the scanner RTL and function_end_checker, which does the comparing.
module tb_function_end_scanner;
   import fes_pkg::*;

   localparam logic [5:0]  OP_ADDI       = 6'd14;
   localparam logic [31:0] WORD_NOP      = 32'h6000_0000;
   localparam int          RESULT_TARGET = 1350;
   localparam int          PHASE_RESULTS = 170;
   localparam int          SETTLE_CYCLES = 8;
   localparam int          CYCLE_LIMIT   = 500000;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_push = 1'b0;
   logic        req_full;
   logic        req_begin_req = 1'b0;
   logic [31:0] req_instr_word = '0;
   logic        req_target_is_epilog = 1'b0;
   logic        rsp_empty;
   logic        rsp_pop = 1'b0;
   logic [31:0] rsp_instr_address;
   logic        rsp_block_end;
   logic        rsp_function_done;
   logic [2:0]  rsp_end_reason;
   logic [31:0] rsp_final_end;
   logic        rsp_ran_under;
   logic        csr_we = 1'b0;
   logic        csr_index = CSR_START_ADDR;
   logic [31:0] csr_data = '0;

   int mismatches;
   int awaited;
   int predicted;
   int cycles = 0;
   bit send_calm = 1'b0;
   bit take_calm = 1'b0;

   function_end_scanner dut (
      .clock                (clock),
      .reset                (reset),
      .req_push             (req_push),
      .req_full             (req_full),
      .req_begin_req        (req_begin_req),
      .req_instr_word       (req_instr_word),
      .req_target_is_epilog (req_target_is_epilog),
      .rsp_empty            (rsp_empty),
      .rsp_pop              (rsp_pop),
      .rsp_instr_address    (rsp_instr_address),
      .rsp_block_end        (rsp_block_end),
      .rsp_function_done    (rsp_function_done),
      .rsp_end_reason       (rsp_end_reason),
      .rsp_final_end        (rsp_final_end),
      .rsp_ran_under        (rsp_ran_under),
      .csr_we               (csr_we),
      .csr_index            (csr_index),
      .csr_data             (csr_data)
   );

   function_end_checker watch (
      .clock                (clock),
      .reset                (reset),
      .req_push             (req_push),
      .req_full             (req_full),
      .req_begin_req        (req_begin_req),
      .req_instr_word       (req_instr_word),
      .req_target_is_epilog (req_target_is_epilog),
      .rsp_empty            (rsp_empty),
      .rsp_pop              (rsp_pop),
      .rsp_instr_address    (rsp_instr_address),
      .rsp_block_end        (rsp_block_end),
      .rsp_function_done    (rsp_function_done),
      .rsp_end_reason       (rsp_end_reason),
      .rsp_final_end        (rsp_final_end),
      .rsp_ran_under        (rsp_ran_under),
      .csr_we               (csr_we),
      .csr_index            (csr_index),
      .csr_data             (csr_data),
      .mismatches           (mismatches),
      .awaited              (awaited),
      .predicted            (predicted)
   );

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles >= CYCLE_LIMIT) begin
         $display("Timed out after %0d cycles", cycles);
         $display("Testbench completed WITH ERRORS");
         $finish;
      end
   end

   // Gap before a word; now and then toggle into a stretch with no idling at all.
   function automatic int draw_gap(inout bit calm);
      if ($urandom_range(0, 31) == 0)
         calm = !calm;
      return calm ? 0 : $urandom_range(0, 15);
   endfunction

   function automatic logic [31:0] uncond_branch(input logic [23:0] li, input logic aa,
                                                 input logic lk);
      return {OP_B, li, aa, lk};
   endfunction

   function automatic logic [31:0] cond_branch(input logic [13:0] bd, input logic aa,
                                               input logic lk);
      logic [31:0] r;
      r = $urandom();
      return {OP_BC, r[25:16], bd, aa, lk};
   endfunction

   function automatic logic [31:0] reg_branch(input logic [9:0] xo, input logic lk);
      logic [31:0] r;
      r = $urandom();
      return {OP_XL, r[25:11], xo, lk};
   endfunction

   function automatic logic [31:0] mflr_word();
      logic [31:0] r;
      r = $urandom();
      return {OP_X, r[25:21], SPR_LINK[4:0], SPR_LINK[9:5], XO_MFSPR, 1'b0};
   endfunction

   function automatic logic [31:0] body_word();
      logic [31:0] r;
      int          k;
      r = $urandom();
      k = $urandom_range(1, 12);
      case ($urandom_range(0, 19))
         10, 11:  return r;
         12, 13:  return cond_branch(14'(k), 1'b0, r[0]);
         14:      return cond_branch(14'(-k), 1'b0, 1'b0);
         15:      return uncond_branch(r[31:8], 1'b0, 1'b1);
         16:      return reg_branch(r[0] ? XO_BCLR : XO_BCCTR, r[1]);
         17:      return r[0] ? mflr_word() : {OP_X, r[25:11], XO_MFSPR, 1'b0};
         18:      return uncond_branch(24'(k), 1'b0, 1'b0);
         19:      return cond_branch(r[13:0], r[14], r[15]);
         default: return {OP_ADDI, r[25:0]};
      endcase
   endfunction

   task automatic push_word(input logic begin_req, input logic [31:0] word,
                            input logic epilog);
      int gap;
      gap = draw_gap(send_calm);
      if (gap > 0) begin
         req_push <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_push             <= 1'b1;
      req_begin_req        <= begin_req;
      req_instr_word       <= word;
      req_target_is_epilog <= epilog;
      do @(posedge clock); while (req_full);
   endtask

   // Hold the sender until every result is back, then let the pipe empty.
   task automatic settle();
      req_push <= 1'b0;
      @(negedge clock);
      while (awaited != 0) @(negedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_cfg(input logic [31:0] start_at, input logic [31:0] end_at);
      csr_we    <= 1'b1;
      csr_index <= CSR_START_ADDR;
      csr_data  <= start_at;
      @(posedge clock);
      csr_index <= CSR_EXPECTED_END;
      csr_data  <= end_at;
      @(posedge clock);
      csr_we    <= 1'b0;
   endtask

   // One well-formed function: opening word, a body, then a likely ending word.
   task automatic run_scan();
      logic [31:0] r;
      int          len;
      int          k;
      r   = $urandom();
      len = ($urandom_range(0, 7) == 0) ? $urandom_range(20, 60) : $urandom_range(0, 12);
      push_word(1'b1, r[0] ? mflr_word() : body_word(), r[1] & r[2]);
      for (int i = 0; i < len; i++)
         push_word($urandom_range(0, 39) == 0, body_word(), $urandom_range(0, 7) == 0);
      r = $urandom();
      k = $urandom_range(1, 16);
      case ($urandom_range(0, 6))
         0: push_word(1'b0, WORD_RETURN_LR, r[0]);
         1: push_word(1'b0, WORD_JUMP_CTR, r[0]);
         2: push_word(1'b0, uncond_branch(24'(-k), 1'b0, 1'b0), 1'b0);
         3: push_word(1'b0, r[0] ? uncond_branch({16'h0, r[15:8]}, 1'b1, 1'b0)
                                  : uncond_branch(24'(-(k * 1024)), 1'b0, 1'b0), 1'b0);
         4: push_word(1'b0, uncond_branch(24'(k), 1'b0, 1'b0), 1'b1);
         5: push_word(1'b0, '0, r[0]);
         default: push_word(1'b0, $urandom(), r[0]);
      endcase
      // stray words after the ending word; the block drops them once the scan has ended
      if ($urandom_range(0, 3) == 0)
         repeat ($urandom_range(1, 3)) push_word(1'b0, $urandom(), r[1]);
   endtask

   initial begin : result_side
      int stall;
      while (reset) @(posedge clock);
      forever begin
         stall = draw_gap(take_calm);
         if (stall > 0) begin
            rsp_pop <= 1'b0;
            repeat (stall) @(posedge clock);
         end
         rsp_pop <= 1'b1;
         do @(posedge clock); while (rsp_empty);
      end
   end

   initial begin : stimulus
      int          phase;
      int          goal;
      logic [31:0] base;
      logic [31:0] bound;

      repeat (10) @(posedge clock);
      reset <= 1'b0;

      write_cfg(32'h0000_1000, '0);
      push_word(1'b0, WORD_NOP, 1'b0);                       // idle, dropped
      push_word(1'b1, mflr_word(), 1'b0);
      push_word(1'b0, cond_branch(14'd8, 1'b0, 1'b0), 1'b0);   // target ahead of return
      push_word(1'b0, WORD_RETURN_LR, 1'b0);
      push_word(1'b1, '0, 1'b0);                              // restart on a zero word
      push_word(1'b1, uncond_branch(24'd2, 1'b0, 1'b0), 1'b0); // leaf thunk
      push_word(1'b1, WORD_NOP, 1'b0);
      push_word(1'b0, uncond_branch(24'hFF_FFFF, 1'b0, 1'b0), 1'b0);
      push_word(1'b1, mflr_word(), 1'b0);
      push_word(1'b0, uncond_branch(24'd0, 1'b1, 1'b0), 1'b0); // tail call to zero
      push_word(1'b1, mflr_word(), 1'b0);
      push_word(1'b0, uncond_branch(24'd64, 1'b0, 1'b0), 1'b1);
      push_word(1'b1, WORD_JUMP_CTR, 1'b0);
      push_word(1'b1, mflr_word(), 1'b0);
      push_word(1'b0, reg_branch(XO_BCLR, 1'b0), 1'b0);
      push_word(1'b0, 32'hFFFF_FFFF, 1'b1);
      push_word(1'b0, uncond_branch(24'h00_0040, 1'b0, 1'b1), 1'b0);
      push_word(1'b0, reg_branch(XO_BCCTR, 1'b1), 1'b0);
      push_word(1'b0, cond_branch(14'h3FFF, 1'b1, 1'b1), 1'b0);
      push_word(1'b0, WORD_RETURN_LR, 1'b0);

      // bounded scans: early return runs under, plain words run over
      settle();
      write_cfg(32'h0000_2000, 32'h0000_2008);
      push_word(1'b1, WORD_RETURN_LR, 1'b0);
      push_word(1'b1, WORD_NOP, 1'b0);
      push_word(1'b0, WORD_NOP, 1'b0);
      push_word(1'b0, WORD_NOP, 1'b0);

      phase = 0;
      while (predicted < RESULT_TARGET) begin
         settle();
         base = $urandom() & 32'hFFFF_FFFC;
         case (phase)
            0:       bound = '0;
            1: begin
               base  = 32'hFFFF_FFFC;
               bound = 32'hFFFF_FFFC;
            end
            2: begin
               base  = 32'hFFFF_FFF0;
               bound = '0;
            end
            default:
               case ($urandom_range(0, 3))
                  0: bound = '0;
                  1: bound = base + 32'(4 * $urandom_range(0, 24));
                  2: bound = $urandom() & 32'hFFFF_FFFC;
                  default: begin
                     base  = '0;
                     bound = 32'hFFFF_FFFC;
                  end
               endcase
         endcase
         write_cfg(base, bound);
         goal = predicted + PHASE_RESULTS;
         while (predicted < goal)
            run_scan();
         phase++;
      end

      settle();
      if (mismatches == 0 && awaited == 0)
         $display("Testbench completed without errors");
      else
         $display("Testbench completed WITH ERRORS");
      $finish;
   end

endmodule

// File: function_end_scanner.f
sv/fes_pkg.sv
sv/fes_fifo.sv
sv/fes_decode.sv
sv/fes_exec.sv
sv/function_end_scanner.sv
verif/function_end_checker.sv
verif/tb_function_end_scanner.sv
